// ----- sv/btnf_pkg.sv -----
// ----------------------------------------------------------------------------
// btnf_pkg
// Shared types, constants and tag helpers for the boundary-tag allocator.
// ----------------------------------------------------------------------------
package btnf_pkg;

	localparam int HEAP_BYTES = 65536;
	localparam int WORDS      = HEAP_BYTES / 4;
	localparam int IW         = $clog2(WORDS);
	localparam int AW         = $clog2(HEAP_BYTES) + 3;
	localparam int TW         = 17;
	localparam int NW         = $clog2(HEAP_BYTES / 8 + 3);
	localparam int WALK_CAP   = HEAP_BYTES / 8 + 2;
	localparam int SPLIT_MIN  = 16;
	localparam int INIT_CHUNK = 1 << 12;
	localparam int LIST_START = 8;
	localparam int EXT_RESET  = 4096;
	localparam int BRK_RESET  = 16 + INIT_CHUNK;

	// Status codes of a result beat.
	localparam logic [1:0] STS_DONE = 2'd0;
	localparam logic [1:0] STS_OOM  = 2'd1;
	localparam logic [1:0] STS_ZERO = 2'd2;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [AW-1:0] addr_t;
	typedef logic [TW-1:0] tag_t;
	typedef logic [IW-1:0] idx_t;

	// Build a tag word from a size and the two flag bits.
	function automatic tag_t mk_tag(addr_t sz, logic prev, logic alloc);
		return {sz[TW-1:3], 1'b0, prev, alloc};
	endfunction

	// Size field of a tag, widened to an address.
	function automatic addr_t tag_size(tag_t t);
		return {{(AW-TW){1'b0}}, t[TW-1:3], 3'b000};
	endfunction

	// Contents of the tag store as left by initialization.
	function automatic tag_t init_tag(idx_t i);
		tag_t v;
		v = '0;
		if (i == idx_t'(1) || i == idx_t'(2)) begin
			v = mk_tag(addr_t'(8), 1'b0, 1'b1);
		end else if (i == idx_t'(3) || i == idx_t'((INIT_CHUNK + 8) / 4)) begin
			v = mk_tag(addr_t'(INIT_CHUNK), 1'b1, 1'b0);
		end else if (i == idx_t'((INIT_CHUNK + 12) / 4)) begin
			v = mk_tag(addr_t'(0), 1'b0, 1'b1);
		end
		return v;
	endfunction

endpackage

// ----- sv/btnf_tag_ram.sv -----
// ----------------------------------------------------------------------------
// btnf_tag_ram
// Tag store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btnf_tag_ram (
	input  logic           clk,
	input  logic           we,
	input  btnf_pkg::idx_t waddr,
	input  btnf_pkg::tag_t wdata,
	input  logic           re,
	input  btnf_pkg::idx_t raddr,
	output btnf_pkg::tag_t rdata
);
	import btnf_pkg::*;

	tag_t mem [WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/boundary_tag_next_fit_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_next_fit_allocator_unit
// Next-fit heap allocator over boundary tags held in a tag store with one read
// and one write port.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  command   start, busy, operation, request_size,          in (busy out)
//            block_address
//  result    done, result_address, status                   out
//  config    psel, penable, pwrite, paddr, pwdata,          in/out
//            prdata, pready
//
//  A command beat is taken when start is high and busy is low. A sequencer
//  walks block headers through the tag store, one tag read or write a cycle.
//  An allocate visits blocks from the rover on, a pass ending at the heap end
//  or on its block limit, and, when no block fits, grows the heap before it
//  places the block (out of memory when the arena is full). A free whose
//  header is not marked allocated answers without a change. Zero-size requests
//  and frees with a bad address answer in the cycle after acceptance; other
//  results appear in the cycle after the last sequencer step. After reset a
//  clearing pass over all 16384 tag words rebuilds the initial heap with busy
//  high. The result beat is shown for one cycle on done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module boundary_tag_next_fit_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [16:0] request_size,
	input  logic [15:0] block_address,
	output logic        done,
	output logic [15:0] result_address,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import btnf_pkg::*;

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_FRD  = 5'd2;
	localparam logic [4:0] S_FCHK = 5'd3;
	localparam logic [4:0] S_GROW = 5'd4;
	localparam logic [4:0] S_GRD  = 5'd5;
	localparam logic [4:0] S_GW1  = 5'd6;
	localparam logic [4:0] S_GW2  = 5'd7;
	localparam logic [4:0] S_GW3  = 5'd8;
	localparam logic [4:0] S_MRG  = 5'd9;
	localparam logic [4:0] S_M1   = 5'd10;
	localparam logic [4:0] S_M2   = 5'd11;
	localparam logic [4:0] S_M3   = 5'd12;
	localparam logic [4:0] S_M4   = 5'd13;
	localparam logic [4:0] S_MWA2 = 5'd14;
	localparam logic [4:0] S_MWB2 = 5'd15;
	localparam logic [4:0] S_MWC2 = 5'd16;
	localparam logic [4:0] S_MWC3 = 5'd17;
	localparam logic [4:0] S_MWD2 = 5'd18;
	localparam logic [4:0] S_MROV = 5'd19;
	localparam logic [4:0] S_PRD  = 5'd20;
	localparam logic [4:0] S_P1   = 5'd21;
	localparam logic [4:0] S_PS2  = 5'd22;
	localparam logic [4:0] S_PS3  = 5'd23;
	localparam logic [4:0] S_PN2  = 5'd24;
	localparam logic [4:0] S_PN3  = 5'd25;
	localparam logic [4:0] S_PN4  = 5'd26;
	localparam logic [4:0] S_PN5  = 5'd27;
	localparam logic [4:0] S_FR1  = 5'd28;

	logic [4:0]  state_q;
	idx_t        clr_q;
	addr_t       rover_q, brk_q, old_q, asize_q, bp_q, nx_q, pb_q;
	addr_t       own_q, ns_q, sz_q, whole_q, left_q, f_q;
	tag_t        nxt_q;
	logic        pa_q, pp_q, p_q, pass_q, mret_q;
	logic [NW-1:0] n_q;
	logic [16:0] ext_q;
	logic        done_q;
	logic [15:0] res_addr_q;
	logic [1:0]  status_q;
	logic        rz_s1;

	logic        rd_req, wr_req;
	addr_t       rd_addr, wr_addr;
	tag_t        wr_data, ram_rdata, tag;
	addr_t       tsz, free_a, grow_bytes, grow_sz, left_c;
	logic        free_ok, end_pass, split_c, ram_we;
	idx_t        ram_waddr;
	tag_t        ram_wdata;

	// Tag read that honors the break: anything at or past it reads as zero.
	assign tag    = rz_s1 ? '0 : ram_rdata;
	assign tsz    = tag_size(tag);
	assign free_a = {{(AW-16){1'b0}}, block_address};
	assign free_ok = (block_address[2:0] == 3'b000) &&
		(free_a >= addr_t'(LIST_START + 8)) && (free_a < brk_q);
	assign end_pass = (n_q >= NW'(WALK_CAP)) || (pass_q && !(rover_q < old_q));
	assign grow_bytes = (asize_q > {2'b00, ext_q}) ? asize_q : {2'b00, ext_q};
	assign grow_sz = {grow_bytes[AW-1:3] + (AW-3)'(grow_bytes[2]), 3'b000};
	assign left_c  = tsz - asize_q;
	assign split_c = left_c > addr_t'(SPLIT_MIN);

	// Tag store port requests for each sequencer step.
	always_comb begin
		rd_req  = 1'b0;
		rd_addr = bp_q - addr_t'(4);
		wr_req  = 1'b0;
		wr_addr = bp_q - addr_t'(4);
		wr_data = '0;
		case (state_q)
			S_IDLE: begin
				rd_req  = start && (operation == OP_FREE) && free_ok;
				rd_addr = free_a - addr_t'(4);
			end
			S_FRD: begin
				rd_req  = !end_pass;
				rd_addr = rover_q - addr_t'(4);
			end
			S_GRD, S_MRG, S_PRD: begin
				rd_req = 1'b1;
			end
			S_GW1: begin
				wr_req  = 1'b1;
				wr_data = mk_tag(sz_q, tag[1], 1'b0);
			end
			S_GW2: begin
				wr_req  = 1'b1;
				wr_addr = bp_q + sz_q - addr_t'(8);
				wr_data = mk_tag(sz_q, p_q, 1'b0);
			end
			S_GW3: begin
				wr_req  = 1'b1;
				wr_addr = bp_q + sz_q - addr_t'(4);
				wr_data = mk_tag(addr_t'(0), 1'b0, 1'b1);
			end
			S_M1: begin
				rd_req  = 1'b1;
				rd_addr = bp_q + tsz - addr_t'(4);
			end
			S_M2: begin
				if (pa_q && tag[0]) begin
					wr_req  = 1'b1;
					wr_addr = bp_q + own_q - addr_t'(8);
					wr_data = mk_tag(own_q, 1'b1, 1'b0);
				end else if (pa_q) begin
					wr_req  = 1'b1;
					wr_data = mk_tag(own_q + tsz, 1'b1, 1'b0);
				end else begin
					rd_req  = 1'b1;
					rd_addr = bp_q - addr_t'(8);
				end
			end
			S_M3: begin
				rd_req  = 1'b1;
				rd_addr = bp_q - tsz - addr_t'(4);
			end
			S_M4: begin
				wr_req = 1'b1;
				if (nxt_q[0]) begin
					wr_addr = bp_q + own_q - addr_t'(8);
					wr_data = mk_tag(own_q + tsz, tag[1], 1'b0);
				end else begin
					wr_addr = pb_q - addr_t'(4);
					wr_data = mk_tag(own_q + tsz + ns_q, tag[1], 1'b0);
				end
			end
			S_MWA2, S_MWC3: begin
				wr_req  = 1'b1;
				wr_addr = nx_q - addr_t'(4);
				wr_data = {nxt_q[TW-1:2], 1'b0, nxt_q[0]};
			end
			S_MWB2: begin
				wr_req  = 1'b1;
				wr_addr = bp_q + sz_q - addr_t'(8);
				wr_data = mk_tag(sz_q, 1'b1, 1'b0);
			end
			S_MWC2: begin
				wr_req  = 1'b1;
				wr_addr = pb_q - addr_t'(4);
				wr_data = mk_tag(sz_q, pp_q, 1'b0);
			end
			S_MWD2: begin
				wr_req  = 1'b1;
				wr_addr = nx_q + ns_q - addr_t'(8);
				wr_data = mk_tag(sz_q, pp_q, 1'b0);
			end
			S_P1: begin
				wr_req  = 1'b1;
				wr_data = split_c ? mk_tag(asize_q, tag[1], 1'b1) :
					mk_tag(tsz, tag[1], 1'b1);
			end
			S_PS2: begin
				wr_req  = 1'b1;
				wr_addr = bp_q + asize_q - addr_t'(4);
				wr_data = mk_tag(left_q, 1'b1, 1'b0);
			end
			S_PS3: begin
				wr_req  = 1'b1;
				wr_addr = bp_q + whole_q - addr_t'(8);
				wr_data = mk_tag(left_q, 1'b1, 1'b0);
			end
			S_PN2: begin
				rd_req  = 1'b1;
				rd_addr = bp_q + whole_q - addr_t'(4);
			end
			S_PN3: begin
				wr_req  = 1'b1;
				wr_addr = bp_q + whole_q - addr_t'(4);
				wr_data = tag | tag_t'(2);
			end
			S_PN4: begin
				rd_req  = 1'b1;
				rd_addr = f_q;
			end
			S_PN5: begin
				wr_req  = 1'b1;
				wr_addr = f_q;
				wr_data = tag | tag_t'(2);
			end
			S_FR1: begin
				wr_req  = tag[0];
				wr_data = {tag[TW-1:3], 1'b0, tag[1], 1'b0};
			end
			default: begin
			end
		endcase
	end

	// The clearing pass owns the write port; otherwise writes past the break drop.
	assign ram_we    = (state_q == S_CLR) || (wr_req && (wr_addr < brk_q));
	assign ram_waddr = (state_q == S_CLR) ? clr_q : wr_addr[IW+1:2];
	assign ram_wdata = (state_q == S_CLR) ? init_tag(clr_q) : wr_data;

	btnf_tag_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_req),
		.raddr (rd_addr[IW+1:2]),
		.rdata (ram_rdata)
	);

	// Read-past-break flag travels with the read data.
	always_ff @(posedge clk) begin
		if (rd_req) begin
			rz_s1 <= rd_addr >= brk_q;
		end
	end

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {15'd0, ext_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 17'(EXT_RESET);
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			ext_q <= pwdata[16:0];
		end
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			rover_q <= addr_t'(LIST_START);
			brk_q   <= addr_t'(BRK_RESET);
			n_q     <= '0;
			pass_q  <= 1'b0;
			mret_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						res_addr_q <= '0;
						status_q   <= STS_DONE;
						if (operation == OP_ALLOC) begin
							if (request_size == '0) begin
								done_q   <= 1'b1;
								status_q <= STS_ZERO;
							end else begin
								asize_q <= ({2'b00, request_size} + addr_t'(15)) &
									~addr_t'(7);
								old_q   <= rover_q;
								n_q     <= '0;
								pass_q  <= 1'b0;
								state_q <= S_FRD;
							end
						end else if (free_ok) begin
							bp_q    <= free_a;
							state_q <= S_FR1;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_FRD: begin
					if (end_pass) begin
						if (!pass_q) begin
							rover_q <= addr_t'(LIST_START);
							n_q     <= '0;
							pass_q  <= 1'b1;
						end else begin
							state_q <= S_GROW;
						end
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (tsz == '0) begin
						if (!pass_q) begin
							rover_q <= addr_t'(LIST_START);
							n_q     <= '0;
							pass_q  <= 1'b1;
							state_q <= S_FRD;
						end else begin
							state_q <= S_GROW;
						end
					end else if (!tag[0] && (asize_q <= tsz)) begin
						bp_q    <= rover_q;
						state_q <= S_PRD;
					end else begin
						rover_q <= rover_q + tsz;
						n_q     <= n_q + NW'(1);
						state_q <= S_FRD;
					end
				end
				S_GROW: begin
					if ((grow_sz == '0) || (grow_sz > addr_t'(HEAP_BYTES) - brk_q)) begin
						done_q     <= 1'b1;
						status_q   <= STS_OOM;
						res_addr_q <= '0;
						state_q    <= S_IDLE;
					end else begin
						bp_q    <= brk_q;
						sz_q    <= grow_sz;
						brk_q   <= brk_q + grow_sz;
						state_q <= S_GRD;
					end
				end
				S_GRD: begin
					state_q <= S_GW1;
				end
				S_GW1: begin
					p_q     <= tag[1];
					state_q <= S_GW2;
				end
				S_GW2: begin
					state_q <= S_GW3;
				end
				S_GW3: begin
					mret_q  <= 1'b0;
					state_q <= S_MRG;
				end
				S_MRG: begin
					state_q <= S_M1;
				end
				S_M1: begin
					own_q   <= tsz;
					pa_q    <= tag[1];
					nx_q    <= bp_q + tsz;
					state_q <= S_M2;
				end
				S_M2: begin
					nxt_q <= tag;
					ns_q  <= tsz;
					if (pa_q && tag[0]) begin
						sz_q    <= own_q;
						state_q <= S_MWA2;
					end else if (pa_q) begin
						sz_q    <= own_q + tsz;
						state_q <= S_MWB2;
					end else begin
						state_q <= S_M3;
					end
				end
				S_M3: begin
					pb_q    <= bp_q - tsz;
					state_q <= S_M4;
				end
				S_M4: begin
					pp_q <= tag[1];
					bp_q <= pb_q;
					if (nxt_q[0]) begin
						sz_q    <= own_q + tsz;
						state_q <= S_MWC2;
					end else begin
						sz_q    <= own_q + tsz + ns_q;
						state_q <= S_MWD2;
					end
				end
				S_MWC2: begin
					state_q <= S_MWC3;
				end
				S_MWA2, S_MWB2, S_MWC3, S_MWD2: begin
					state_q <= S_MROV;
				end
				S_MROV: begin
					if ((rover_q > bp_q) && (rover_q < bp_q + sz_q)) begin
						rover_q <= bp_q;
					end
					if (mret_q) begin
						done_q     <= 1'b1;
						status_q   <= STS_DONE;
						res_addr_q <= '0;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_P1;
				end
				S_P1: begin
					whole_q <= tsz;
					left_q  <= left_c;
					state_q <= split_c ? S_PS2 : S_PN2;
				end
				S_PS2: begin
					state_q <= S_PS3;
				end
				S_PN2: begin
					state_q <= S_PN3;
				end
				S_PN3: begin
					f_q <= bp_q + whole_q + tsz - addr_t'(8);
					if (tag[0]) begin
						done_q     <= 1'b1;
						status_q   <= STS_DONE;
						res_addr_q <= bp_q[15:0];
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_PN4;
					end
				end
				S_PN4: begin
					state_q <= S_PN5;
				end
				S_PS3, S_PN5: begin
					done_q     <= 1'b1;
					status_q   <= STS_DONE;
					res_addr_q <= bp_q[15:0];
					state_q    <= S_IDLE;
				end
				S_FR1: begin
					if (tag[0]) begin
						mret_q  <= 1'b1;
						state_q <= S_MRG;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign result_address = res_addr_q;
	assign status         = status_q;

endmodule

// ----- verif/boundary_tag_next_fit_allocator_unit_test.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_next_fit_allocator_unit_test
// Self-checking test of the next-fit boundary-tag heap allocator. A built-in
// heap model mirrors the tag store, the rover and the break. It predicts
// every result beat, and each beat is checked against that prediction.
// ----------------------------------------------------------------------------
module boundary_tag_next_fit_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import btnf_pkg::*;

	localparam int unsigned ARENA = 65536;
	localparam int unsigned TAG_WORDS = ARENA / 4;
	localparam int unsigned SEARCH_CAP = ARENA / 8 + 2;
	localparam logic [2:0] REG_EXTEND = 3'd0;

	typedef struct packed {
		logic [15:0] result_address;
		logic [1:0]  status;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = OP_ALLOC;
	logic [16:0] request_size = '0;
	logic [15:0] block_address = '0;
	logic        done;
	logic [15:0] result_address;
	logic [1:0]  status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Heap model state.
	int unsigned   heap_tags [TAG_WORDS];
	int unsigned   rover_addr;
	int unsigned   break_addr;
	int unsigned   first_block;
	int unsigned   extend_min;
	alloc_result_t pending_results[$];
	logic [15:0]   live_blocks[$];
	int            fail_count = 0;
	int            beats_seen = 0;
	int            oom_seen = 0;

	boundary_tag_next_fit_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .request_size(request_size),
		.block_address(block_address), .done(done),
		.result_address(result_address), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#200ms;
		$display("status: fail");
		$finish;
	end

	// Tag access; anything at or past the break reads as zero and ignores writes.
	function automatic int unsigned tag_rd(int unsigned a);
		if (a >= break_addr || (a >> 2) >= TAG_WORDS) begin
			return 0;
		end
		return heap_tags[a >> 2];
	endfunction

	function automatic void tag_wr(int unsigned a, int unsigned v);
		if (a >= break_addr || (a >> 2) >= TAG_WORDS) begin
			return;
		end
		heap_tags[a >> 2] = v;
	endfunction

	function automatic int unsigned tag_sz(int unsigned a);
		return tag_rd(a) & ~32'd7;
	endfunction

	// Merge a free block with its free neighbors and pull the rover back.
	function automatic int unsigned coalesce_block(int unsigned bp);
		int unsigned own, total, pa, nx, na, pb, pp, ns;
		own = tag_sz(bp - 4);
		total = own;
		pa = tag_rd(bp - 4) & 2;
		nx = bp + own;
		na = tag_rd(nx - 4) & 1;
		if (pa != 0 && na != 0) begin
			tag_wr(bp + total - 8, total | pa);
			tag_wr(nx - 4, tag_rd(nx - 4) & ~32'd2);
		end else if (pa != 0) begin
			total += tag_sz(nx - 4);
			tag_wr(bp - 4, total | pa);
			tag_wr(bp + total - 8, total | pa);
		end else if (na != 0) begin
			pb = bp - tag_sz(bp - 8);
			pp = tag_rd(pb - 4) & 2;
			total += tag_sz(pb - 4);
			tag_wr(bp + own - 8, total | pp);
			tag_wr(pb - 4, total | pp);
			tag_wr(nx - 4, tag_rd(nx - 4) & ~32'd2);
			bp = pb;
		end else begin
			pb = bp - tag_sz(bp - 8);
			pp = tag_rd(pb - 4) & 2;
			ns = tag_sz(nx - 4);
			total += tag_sz(pb - 4) + ns;
			tag_wr(pb - 4, total | pp);
			tag_wr(nx + ns - 8, total | pp);
			bp = pb;
		end
		if (rover_addr > bp && rover_addr < bp + total) begin
			rover_addr = bp;
		end
		return bp;
	endfunction

	// Raise the break; zero means the arena is exhausted.
	function automatic int unsigned grow_heap(int unsigned bytes);
		int unsigned w, sz, bp, p;
		w = bytes >> 2;
		sz = (w & 1) ? (w + 1) * 4 : w * 4;
		if (sz == 0 || break_addr > ARENA || sz > ARENA - break_addr) begin
			return 0;
		end
		bp = break_addr;
		break_addr += sz;
		p = tag_rd(bp - 4) & 2;
		tag_wr(bp - 4, sz | p);
		tag_wr(bp + sz - 8, sz | p);
		tag_wr(bp + sz - 4, 1);
		return coalesce_block(bp);
	endfunction

	// Next-fit walk from the rover, then from the list start up to the old rover.
	function automatic int unsigned rover_search(int unsigned asize);
		int unsigned old, s;
		old = rover_addr;
		for (int unsigned n = 0; n < SEARCH_CAP; n++) begin
			s = tag_sz(rover_addr - 4);
			if (s == 0) begin
				break;
			end
			if ((tag_rd(rover_addr - 4) & 1) == 0 && asize <= s) begin
				return rover_addr;
			end
			rover_addr += s;
		end
		rover_addr = first_block;
		for (int unsigned n = 0; n < SEARCH_CAP && rover_addr < old; n++) begin
			s = tag_sz(rover_addr - 4);
			if (s == 0) begin
				break;
			end
			if ((tag_rd(rover_addr - 4) & 1) == 0 && asize <= s) begin
				return rover_addr;
			end
			rover_addr += s;
		end
		return 0;
	endfunction

	// Mark the block used and split off the remainder when it is big enough.
	function automatic void place_block(int unsigned bp, int unsigned asize);
		int unsigned whole, p, left, nb, f;
		whole = tag_sz(bp - 4);
		p = tag_rd(bp - 4) & 2;
		left = whole - asize;
		if (left > 16) begin
			nb = bp + asize;
			tag_wr(bp - 4, asize | 1 | p);
			tag_wr(nb - 4, left | 2);
			tag_wr(nb + left - 8, left | 2);
		end else begin
			nb = bp + whole;
			tag_wr(bp - 4, whole | 1 | p);
			tag_wr(nb - 4, tag_rd(nb - 4) | 2);
			if ((tag_rd(nb - 4) & 1) == 0) begin
				f = nb + tag_sz(nb - 4) - 8;
				tag_wr(f, tag_rd(f) | 2);
			end
		end
	endfunction

	function automatic void heap_init();
		foreach (heap_tags[i]) begin
			heap_tags[i] = 0;
		end
		extend_min = 4096;
		break_addr = 16;
		tag_wr(4, 9);
		tag_wr(8, 9);
		tag_wr(12, 3);
		first_block = 8;
		rover_addr = 8;
		void'(grow_heap(4096));
	endfunction

	// Apply one command beat to the heap model and return its result.
	function automatic alloc_result_t predict_command(logic op, logic [16:0] req,
			logic [15:0] addr);
		alloc_result_t r;
		int unsigned asize, bp, a, h;
		r = '0;
		if (op == OP_ALLOC) begin
			if (req == 0) begin
				r.status = STS_ZERO;
				return r;
			end
			asize = (int'(req) + 15) & ~32'd7;
			bp = rover_search(asize);
			if (bp == 0) begin
				bp = grow_heap(asize > extend_min ? asize : extend_min);
				if (bp == 0) begin
					r.status = STS_OOM;
					return r;
				end
			end
			place_block(bp, asize);
			r.result_address = bp[15:0];
			r.status = STS_DONE;
		end else begin
			a = addr;
			if ((a & 7) == 0 && a >= first_block + 8 && a < break_addr &&
					(tag_rd(a - 4) & 1) != 0) begin
				h = tag_rd(a - 4);
				tag_wr(a - 4, (h & ~32'd7) | (h & 2));
				void'(coalesce_block(a));
			end
			r.status = STS_DONE;
		end
		return r;
	endfunction

	// Observe accepted command beats, register writes and result beats.
	always @(posedge clk) begin
		alloc_result_t exp_r;
		alloc_result_t got_r;
		if (arst_n) begin
			if (done) begin
				beats_seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result beat: result_address %0d status %0d",
						result_address, status);
					fail_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (result_address !== exp_r.result_address) begin
						$error("result_address: expected %0d, got %0d",
							exp_r.result_address, result_address);
						fail_count++;
					end
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				got_r = predict_command(operation, request_size, block_address);
				pending_results.push_back(got_r);
				if (operation == OP_ALLOC && got_r.status == STS_DONE) begin
					live_blocks.push_back(got_r.result_address);
				end
				if (got_r.status == STS_OOM) begin
					oom_seen++;
				end
			end
			if (psel && penable && pwrite && pready && paddr == REG_EXTEND) begin
				extend_min = pwdata & 32'h1FFFF;
			end
		end
	end

	// Send one command beat and return once it has been taken.
	task automatic send_command(logic op, logic [16:0] req, logic [15:0] addr,
			int gap);
		start <= 1'b1;
		operation <= op;
		request_size <= req;
		block_address <= addr;
		do begin
			@(posedge clk);
		end while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	// Register write while the block is idle.
	task automatic set_extend(int unsigned value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_EXTEND;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int pick_gap();
		int k;
		k = int'($urandom_range(99));
		if (k < 60) begin
			return 0;
		end else if (k < 92) begin
			return int'($urandom_range(3, 1));
		end
		return int'($urandom_range(60, 20));
	endfunction

	function automatic logic [16:0] pick_size();
		int k;
		k = int'($urandom_range(99));
		if (k < 70) begin
			return 17'($urandom_range(256, 1));
		end else if (k < 90) begin
			return 17'($urandom_range(4096, 257));
		end else if (k < 98) begin
			return 17'($urandom_range(20000, 4097));
		end
		return 17'($urandom_range(131071, 0));
	endfunction

	// Free a live block, or a random address when none is left.
	task automatic free_live(int gap);
		int idx;
		logic [15:0] a;
		if (live_blocks.size() == 0) begin
			send_command(OP_FREE, 17'($urandom()), 16'($urandom()), gap);
			return;
		end
		idx = int'($urandom_range(live_blocks.size() - 1));
		a = live_blocks[idx];
		live_blocks.delete(idx);
		send_command(OP_FREE, 17'($urandom()), a, gap);
	endtask

	// Edges of the fields, bad frees, exact fits and coalescing on both sides.
	task automatic test_directed();
		logic [15:0] a;
		send_command(OP_ALLOC, 17'd0, 16'hFFFF, pick_gap());
		send_command(OP_ALLOC, 17'd1, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'd24, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'd100, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'd65536, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'h1FFFF, 16'd0, pick_gap());
		send_command(OP_FREE, 17'h1FFFF, 16'd0, pick_gap());
		send_command(OP_FREE, 17'd0, 16'd8, pick_gap());
		send_command(OP_FREE, 17'd0, 16'd21, pick_gap());
		send_command(OP_FREE, 17'd0, 16'hFFF8, pick_gap());
		send_command(OP_FREE, 17'd0, 16'hFFFF, pick_gap());
		// Free the middle block, then a double free of it, then the first and third blocks.
		wait (live_blocks.size() >= 3);
		a = live_blocks[1];
		send_command(OP_FREE, 17'd0, a, pick_gap());
		send_command(OP_FREE, 17'd0, a, pick_gap());
		send_command(OP_FREE, 17'd0, live_blocks[0], pick_gap());
		send_command(OP_FREE, 17'd0, live_blocks[2], pick_gap());
		live_blocks.delete();
		// Exact fit of the whole remaining chunk, leaving no split.
		send_command(OP_ALLOC, 17'd4088, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'd4080, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'd60000, 16'd0, pick_gap());
		send_command(OP_ALLOC, 17'd8, 16'd0, 0);
		send_command(OP_ALLOC, 17'd16, 16'd0, 0);
		drain();
		while (live_blocks.size() != 0) begin
			free_live(0);
		end
	endtask

	// Random traffic: mostly alloc/free of live blocks, some bad frees.
	task automatic test_random(int count);
		int k;
		for (int i = 0; i < count; i++) begin
			k = int'($urandom_range(99));
			if (k < 55) begin
				send_command(OP_ALLOC, pick_size(), 16'($urandom()), pick_gap());
			end else if (k < 93) begin
				free_live(pick_gap());
			end else begin
				send_command(OP_FREE, 17'($urandom()), 16'($urandom()), pick_gap());
			end
		end
	endtask

	// The extend register at 8, at 65536, at a random value between and back at 4096.
	task automatic test_extend_settings();
		set_extend(8);
		test_random(100);
		set_extend(65536);
		test_random(100);
		set_extend($urandom_range(65536, 8));
		test_random(100);
		set_extend(4096);
		test_random(40);
	endtask

	initial begin
		heap_init();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(160);
		test_extend_settings();
		drain();
		$display("Checked %0d result beats, %0d of them out of memory,", beats_seen,
			oom_seen);
		$display("across four extend settings including both extremes.");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
